// ===== design/bfr_pkg.sv =====
// shared types, constants and the crc-16 step for the bootloader frame receiver
// no dependencies
package bfr_pkg;

	// parser position inside a frame, one-hot
	typedef enum logic [9:0] {
		ST_SYNC0   = 10'b00_0000_0001,
		ST_SYNC1   = 10'b00_0000_0010,
		ST_FLAGS   = 10'b00_0000_0100,
		ST_ADDR    = 10'b00_0000_1000,
		ST_TYPE    = 10'b00_0001_0000,
		ST_SECLEN  = 10'b00_0010_0000,
		ST_LEN     = 10'b00_0100_0000,
		ST_DATA    = 10'b00_1000_0000,
		ST_CRC_HI  = 10'b01_0000_0000,
		ST_CRC_LO  = 10'b10_0000_0000
	} parse_state_t;

	localparam logic [7:0] START_BYTE    = 8'hFF;
	localparam logic [7:0] PAD_BYTE      = 8'hFF;
	localparam logic [7:0] MSG_START     = 8'hF1;
	localparam logic [7:0] MSG_PAGE_NUM  = 8'hF2;
	localparam logic [7:0] MSG_PAGE_DATA = 8'hF3;
	localparam logic [7:0] MSG_END       = 8'hF4;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [1:0] STAT_NONE       = 2'd0;
	localparam logic [1:0] STAT_PAGE_READY = 2'd1;
	localparam logic [1:0] STAT_DONE       = 2'd2;

	// page buffer write request
	typedef struct packed {
		logic       en;
		logic [7:0] addr;
		logic [7:0] data;
	} buf_wr_t;

	// one result item
	typedef struct packed {
		logic [1:0] status;
		logic       signal_on;
		logic       error_seen;
		logic [7:0] read_data;
	} result_t;

	// reflected crc-16, one byte
	function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== design/bootloader_frame_receiver.sv =====
// top level of the bootloader frame receiver: stream ports, apb registers,
// input register and result register; depends on bfr_pkg, bfr_parser, bfr_page_buf
//
// usage:
//  - slave stream (s_*) takes one request per beat: s_tuser 0 is a serial byte,
//    s_tuser 1 reads one page buffer entry at read_index
//  - frames are FF FF flags addr type seclen len data[len] crc_hi crc_lo, with a
//    reflected crc-16 (0xA001, init 0xFFFF) over header and data
//  - master stream (m_*) returns exactly one result per request, in order:
//    status, signal line level, error flag and the read byte
//  - a request goes from the input register into the result register, which drives
//    m_tdata; throughput is one request per cycle, limited only by m_tready
//  - the input register and the result register decouple the two sides, so a new
//    request is taken while a finished result still waits on the master side
//  - when m_tready stays low the result holds, the input register fills and then
//    s_tready drops until the result is taken
//  - reset clears the parser to wait for the first start byte, the crc to 0xFFFF,
//    page mode, page number, padded length and signal line; version registers read 0
//  - the page buffer has no reset; entries read as 0xFF until a page data frame
//    sets the padded length
//  - version registers must be written over apb only while the block is idle; not enforced
module bootloader_frame_receiver #(
	parameter int PAGE_SIZE = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // rx_byte[7:0], expected_page[23:8], read_index[30:24]
	input  logic        s_tuser,   // kind[0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // status[1:0], signal_on[2], error_seen[3], read_data[11:4]
	// apb configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// register word index, one word per register
	localparam logic REG_VERSION_MAJOR = 1'b0;
	localparam logic REG_VERSION_MINOR = 1'b1;

	logic              valid_s1;
	logic              kind_s1;
	logic [7:0]        rx_byte_s1;
	logic [15:0]       expected_page_s1;
	logic [6:0]        read_index_s1;
	logic              m_valid_q;
	bfr_pkg::result_t  result_q;
	bfr_pkg::result_t  result;
	bfr_pkg::buf_wr_t  wr;
	logic [7:0]        buf_rdata;
	logic [7:0]        version_major_q;
	logic [7:0]        version_minor_q;
	logic              step;
	logic              s_accept;
	logic              cfg_write;

	// the stage advances when the result register is free or being emptied
	assign step     = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || step;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			kind_s1          <= s_tuser;
			rx_byte_s1       <= s_tdata[7:0];
			expected_page_s1 <= s_tdata[23:8];
			read_index_s1    <= s_tdata[30:24];
		end
	end

	// buffer read is issued as the request enters the input register
	bfr_page_buf #(
		.PAGE_SIZE(PAGE_SIZE)
	) u_page_buf (
		.clk      (clk),
		.rd_en    (s_accept),
		.rd_index (s_tdata[30:24]),
		.wr       (wr),
		.rdata    (buf_rdata)
	);

	bfr_parser #(
		.PAGE_SIZE(PAGE_SIZE)
	) u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.kind          (kind_s1),
		.rx_byte       (rx_byte_s1),
		.expected_page (expected_page_s1),
		.read_index    (read_index_s1),
		.version_major (version_major_q),
		.version_minor (version_minor_q),
		.buf_rdata     (buf_rdata),
		.wr            (wr),
		.result        (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (step) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'h0, result_q.read_data, result_q.error_seen, result_q.signal_on,
		result_q.status};

	// configuration registers
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_major_q <= 8'h00;
			version_minor_q <= 8'h00;
		end else if (cfg_write) begin
			case (paddr[2])
				REG_VERSION_MAJOR: begin
					version_major_q <= pwdata[7:0];
				end
				REG_VERSION_MINOR: begin
					version_minor_q <= pwdata[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_VERSION_MAJOR: begin
				prdata = {24'h000000, version_major_q};
			end
			REG_VERSION_MINOR: begin
				prdata = {24'h000000, version_minor_q};
			end
			default: begin
				prdata = 32'h0000_0000;
			end
		endcase
	end

endmodule

// ===== design/bfr_page_buf.sv =====
// page buffer memory: one write port, one registered read port with write forwarding
// depends on bfr_pkg
module bfr_page_buf #(
	parameter int PAGE_SIZE = 128
) (
	input  logic            clk,
	input  logic            rd_en,
	input  logic [6:0]      rd_index,
	input  bfr_pkg::buf_wr_t wr,
	output logic [7:0]      rdata
);

	localparam int AW = $clog2(PAGE_SIZE);

	logic [7:0]    mem [PAGE_SIZE];
	logic [7:0]    rdata_q;
	logic [8:0]    idx_ext;
	logic [AW-1:0] ra;
	logic [AW-1:0] wa;

	assign idx_ext = {2'b00, rd_index};
	assign ra      = idx_ext[AW-1:0];
	assign wa      = wr.addr[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wa] <= wr.data;
		end
	end

	// a write in the same cycle to the same entry wins
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr.en && (wa == ra)) begin
				rdata_q <= wr.data;
			end else begin
				rdata_q <= mem[ra];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/bfr_parser.sv =====
// frame parser: position tracking, crc check, message actions and read-out select
// depends on bfr_pkg
module bfr_parser #(
	parameter int PAGE_SIZE = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             kind,
	input  logic [7:0]       rx_byte,
	input  logic [15:0]      expected_page,
	input  logic [6:0]       read_index,
	input  logic [7:0]       version_major,
	input  logic [7:0]       version_minor,
	input  logic [7:0]       buf_rdata,
	output bfr_pkg::buf_wr_t wr,
	output bfr_pkg::result_t result
);

	localparam logic [8:0] PAGE_LIMIT = 9'(PAGE_SIZE);

	bfr_pkg::parse_state_t state_q, state_n;
	logic [7:0]  msg_type_q, msg_type_n;
	logic [7:0]  msg_len_q, msg_len_n;
	logic [7:0]  data_cnt_q, data_cnt_n;
	logic [15:0] crc_q, crc_n;
	logic [7:0]  crc_hi_q, crc_hi_n;
	logic        pages_en_q, pages_en_n;
	logic [7:0]  upcoming_q, upcoming_n;
	logic [7:0]  padded_q, padded_n;
	logic        signal_q, signal_n;
	// copies of buffer entries 0 and 1 for the start and page number actions
	logic [7:0]  first_q, first_n;
	logic [7:0]  second_q, second_n;
	logic        err;
	logic [1:0]  status;
	logic [7:0]  rd;
	logic [15:0] crc_fed;
	logic [15:0] crc_got;

	assign crc_fed = bfr_pkg::crc16_feed(crc_q, rx_byte);
	assign crc_got = {crc_hi_q, rx_byte};

	always_comb begin
		state_n    = state_q;
		msg_type_n = msg_type_q;
		msg_len_n  = msg_len_q;
		data_cnt_n = data_cnt_q;
		crc_n      = crc_q;
		crc_hi_n   = crc_hi_q;
		pages_en_n = pages_en_q;
		upcoming_n = upcoming_q;
		padded_n   = padded_q;
		signal_n   = signal_q;
		first_n    = first_q;
		second_n   = second_q;
		err        = 1'b0;
		status     = bfr_pkg::STAT_NONE;
		rd         = 8'h00;
		wr.en      = 1'b0;
		wr.addr    = data_cnt_q;
		wr.data    = rx_byte;

		if (kind) begin
			if (({1'b0, read_index} < padded_q) && ({2'b00, read_index} < PAGE_LIMIT)) begin
				rd = buf_rdata;
			end else begin
				rd = bfr_pkg::PAD_BYTE;
			end
		end else begin
			case (state_q)
				bfr_pkg::ST_SYNC0, bfr_pkg::ST_SYNC1: begin
					if (rx_byte == bfr_pkg::START_BYTE) begin
						state_n = (state_q == bfr_pkg::ST_SYNC0) ? bfr_pkg::ST_SYNC1
							: bfr_pkg::ST_FLAGS;
					end else begin
						err = 1'b1;
						if (pages_en_q) begin
							signal_n   = 1'b1;
							upcoming_n = 8'h00;
						end
						state_n   = bfr_pkg::ST_SYNC0;
						crc_n     = bfr_pkg::CRC_INIT;
						msg_len_n = 8'h00;
						data_cnt_n = 8'h00;
					end
				end
				bfr_pkg::ST_FLAGS: begin
					crc_n   = crc_fed;
					state_n = bfr_pkg::ST_ADDR;
				end
				bfr_pkg::ST_ADDR: begin
					crc_n   = crc_fed;
					state_n = bfr_pkg::ST_TYPE;
				end
				bfr_pkg::ST_TYPE: begin
					crc_n      = crc_fed;
					msg_type_n = rx_byte;
					state_n    = bfr_pkg::ST_SECLEN;
				end
				bfr_pkg::ST_SECLEN: begin
					crc_n   = crc_fed;
					state_n = bfr_pkg::ST_LEN;
				end
				bfr_pkg::ST_LEN: begin
					crc_n      = crc_fed;
					msg_len_n  = rx_byte;
					data_cnt_n = 8'h00;
					state_n    = (rx_byte != 8'h00) ? bfr_pkg::ST_DATA : bfr_pkg::ST_CRC_HI;
				end
				bfr_pkg::ST_DATA: begin
					crc_n = crc_fed;
					// bytes past the page still go into the crc
					if ({1'b0, data_cnt_q} < PAGE_LIMIT) begin
						wr.en = step;
						if (data_cnt_q == 8'd0) begin
							first_n = rx_byte;
						end
						if (data_cnt_q == 8'd1) begin
							second_n = rx_byte;
						end
					end
					data_cnt_n = data_cnt_q + 8'd1;
					if (data_cnt_n >= msg_len_q) begin
						state_n = bfr_pkg::ST_CRC_HI;
					end
				end
				bfr_pkg::ST_CRC_HI: begin
					crc_hi_n = rx_byte;
					state_n  = bfr_pkg::ST_CRC_LO;
				end
				bfr_pkg::ST_CRC_LO: begin
					if (crc_got != crc_q) begin
						err = 1'b1;
						if (pages_en_q) begin
							signal_n   = 1'b1;
							upcoming_n = 8'h00;
						end
					end else if (msg_type_q == bfr_pkg::MSG_START) begin
						signal_n   = 1'b0;
						pages_en_n = !((msg_len_q == 8'd2) && (first_q == version_major)
							&& (second_q == version_minor));
					end else if (msg_type_q == bfr_pkg::MSG_END) begin
						pages_en_n = 1'b0;
						status     = bfr_pkg::STAT_DONE;
					end else if (pages_en_q) begin
						if (msg_type_q == bfr_pkg::MSG_PAGE_NUM) begin
							upcoming_n = first_q;
						end else if (msg_type_q == bfr_pkg::MSG_PAGE_DATA) begin
							if (({1'b0, msg_len_q} > PAGE_LIMIT)
								|| ({8'h00, upcoming_q} != expected_page)) begin
								err        = 1'b1;
								signal_n   = 1'b1;
								upcoming_n = 8'h00;
							end else begin
								padded_n = msg_len_q;
								signal_n = 1'b0;
								status   = bfr_pkg::STAT_PAGE_READY;
							end
						end
					end
					state_n    = bfr_pkg::ST_SYNC0;
					crc_n      = bfr_pkg::CRC_INIT;
					msg_len_n  = 8'h00;
					data_cnt_n = 8'h00;
				end
				default: begin
					state_n    = bfr_pkg::ST_SYNC0;
					crc_n      = bfr_pkg::CRC_INIT;
					msg_len_n  = 8'h00;
					data_cnt_n = 8'h00;
				end
			endcase
		end

		result.status     = status;
		result.signal_on  = signal_n;
		result.error_seen = err;
		result.read_data  = rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= bfr_pkg::ST_SYNC0;
			msg_type_q <= 8'h00;
			msg_len_q  <= 8'h00;
			data_cnt_q <= 8'h00;
			crc_q      <= bfr_pkg::CRC_INIT;
			crc_hi_q   <= 8'h00;
			pages_en_q <= 1'b0;
			upcoming_q <= 8'h00;
			padded_q   <= 8'h00;
			signal_q   <= 1'b0;
		end else if (step) begin
			state_q    <= state_n;
			msg_type_q <= msg_type_n;
			msg_len_q  <= msg_len_n;
			data_cnt_q <= data_cnt_n;
			crc_q      <= crc_n;
			crc_hi_q   <= crc_hi_n;
			pages_en_q <= pages_en_n;
			upcoming_q <= upcoming_n;
			padded_q   <= padded_n;
			signal_q   <= signal_n;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			first_q  <= first_n;
			second_q <= second_n;
		end
	end

endmodule

// ===== tb/bfr_tb_pkg.sv =====
`timescale 1ns / 100ps
// request kinds, register map and the crc-16 step shared by the stimulus and the checker
// depends on bfr_pkg for the crc constants
package bfr_tb_pkg;
	import bfr_pkg::*;

	typedef enum logic {
		KIND_BYTE = 1'b0,
		KIND_READ = 1'b1
	} req_kind_t;

	typedef enum int {
		REG_VER_MAJOR = 0,
		REG_VER_MINOR = 1
	} cfg_reg_t;

	function automatic logic [2:0] reg_addr(input cfg_reg_t r);
		return 3'(int'(r) * 4);
	endfunction

	// reflected crc-16, shifted one bit at a time
	function automatic logic [15:0] crc_after(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] v;
		v = acc ^ {8'h00, b};
		repeat (8) v = {1'b0, v[15:1]} ^ (v[0] ? CRC_POLY : 16'h0000);
		return v;
	endfunction

endpackage

// ===== tb/bfr_checker.sv =====
`timescale 1ns / 100ps
// scoreboard for the bootloader frame receiver: follows the request stream and the apb
// writes, predicts each result and compares it; depends on bfr_pkg and bfr_tb_pkg
module bfr_checker
	import bfr_pkg::*;
	import bfr_tb_pkg::*;
#(
	parameter int PAGE_SIZE = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fails,
	output int          pending
);

	logic [7:0]   ver_major;
	logic [7:0]   ver_minor;
	parse_state_t pos;
	logic [7:0]   msg_type;
	logic [7:0]   msg_len;
	logic [7:0]   data_cnt;
	logic [15:0]  crc;
	logic [7:0]   crc_hi;
	logic         pages_on;
	logic [7:0]   next_page;
	logic [7:0]   pad_len;
	logic         sig;
	logic [7:0]   page_mem [PAGE_SIZE];

	result_t results_due [$];

	function automatic void restart_frame();
		pos = ST_SYNC0;
		crc = CRC_INIT;
		msg_len = 8'h00;
		data_cnt = 8'h00;
	endfunction

	function automatic void frame_error();
		if (pages_on) begin
			sig = 1'b1;
			next_page = 8'h00;
		end
	endfunction

	function automatic result_t predict_result(input logic kind, input logic [7:0] rx,
			input logic [15:0] exp_pg, input logic [6:0] idx);
		result_t r;
		r = '0;
		if (kind == KIND_READ) begin
			if (int'(idx) < int'(pad_len) && int'(idx) < PAGE_SIZE) begin
				r.read_data = page_mem[idx];
			end else begin
				r.read_data = PAD_BYTE;
			end
		end else begin
			case (pos)
				ST_SYNC0, ST_SYNC1: begin
					if (rx != START_BYTE) begin
						r.error_seen = 1'b1;
						frame_error();
						restart_frame();
					end else if (pos == ST_SYNC0) begin
						pos = ST_SYNC1;
					end else begin
						pos = ST_FLAGS;
					end
				end
				ST_FLAGS: begin
					crc = crc_after(crc, rx);
					pos = ST_ADDR;
				end
				ST_ADDR: begin
					crc = crc_after(crc, rx);
					pos = ST_TYPE;
				end
				ST_TYPE: begin
					crc = crc_after(crc, rx);
					msg_type = rx;
					pos = ST_SECLEN;
				end
				ST_SECLEN: begin
					crc = crc_after(crc, rx);
					pos = ST_LEN;
				end
				ST_LEN: begin
					crc = crc_after(crc, rx);
					msg_len = rx;
					data_cnt = 8'h00;
					if (rx != 8'h00) begin
						pos = ST_DATA;
					end else begin
						pos = ST_CRC_HI;
					end
				end
				ST_DATA: begin
					crc = crc_after(crc, rx);
					// bytes past the page only feed the crc
					if (int'(data_cnt) < PAGE_SIZE) begin
						page_mem[data_cnt] = rx;
					end
					data_cnt++;
					if (data_cnt >= msg_len) begin
						pos = ST_CRC_HI;
					end
				end
				ST_CRC_HI: begin
					crc_hi = rx;
					pos = ST_CRC_LO;
				end
				ST_CRC_LO: begin
					if ({crc_hi, rx} != crc) begin
						r.error_seen = 1'b1;
						frame_error();
					end else if (msg_type == MSG_START) begin
						sig = 1'b0;
						pages_on = !(msg_len == 8'd2 && page_mem[0] == ver_major &&
							page_mem[1] == ver_minor);
					end else if (msg_type == MSG_END) begin
						pages_on = 1'b0;
						r.status = STAT_DONE;
					end else if (pages_on && msg_type == MSG_PAGE_NUM) begin
						next_page = page_mem[0];
					end else if (pages_on && msg_type == MSG_PAGE_DATA) begin
						if (int'(msg_len) > PAGE_SIZE || {8'h00, next_page} != exp_pg) begin
							r.error_seen = 1'b1;
							frame_error();
						end else begin
							pad_len = msg_len;
							sig = 1'b0;
							r.status = STAT_PAGE_READY;
						end
					end
					restart_frame();
				end
				default: restart_frame();
			endcase
		end
		r.signal_on = sig;
		return r;
	endfunction

	function automatic void cmp_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			ver_major = 8'h00;
			ver_minor = 8'h00;
			msg_type = 8'h00;
			crc_hi = 8'h00;
			pages_on = 1'b0;
			next_page = 8'h00;
			pad_len = 8'h00;
			sig = 1'b0;
			restart_frame();
			results_due.delete();
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					$error("result %h with no request outstanding", m_tdata);
					fails++;
				end else begin
					want = results_due.pop_front();
					cmp_field("status", want.status, m_tdata[1:0]);
					cmp_field("signal_on", want.signal_on, m_tdata[2]);
					cmp_field("error_seen", want.error_seen, m_tdata[3]);
					cmp_field("read_data", want.read_data, m_tdata[11:4]);
				end
			end
			if (s_tvalid && s_tready) begin
				results_due.push_back(predict_result(s_tuser, s_tdata[7:0], s_tdata[23:8],
					s_tdata[30:24]));
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr == reg_addr(REG_VER_MAJOR)) begin
					ver_major = pwdata[7:0];
				end else if (paddr == reg_addr(REG_VER_MINOR)) begin
					ver_minor = pwdata[7:0];
				end
			end
			pending = results_due.size();
		end
	end

endmodule

// ===== tb/bootloader_frame_receiver_tb.sv =====
`timescale 1ns / 100ps
// testbench top for the bootloader frame receiver: clock, reset, request and result
// stream drivers, apb writes and the verdict; depends on bfr_pkg, bfr_tb_pkg, bfr_checker
module bootloader_frame_receiver_tb;
	import bfr_pkg::*;
	import bfr_tb_pkg::*;

	localparam int PAGE_SIZE     = 128;
	localparam int REQ_TARGET    = 1000;
	localparam int CYCLE_LIMIT   = 300000;
	// result register plus input register, with some margin
	localparam int SETTLE_CYCLES = 8;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;   // rx_byte[7:0], expected_page[23:8], read_index[30:24]
	logic        s_tuser  = 1'b0; // kind[0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;         // status[1:0], signal_on[2], error_seen[3], read_data[11:4]
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	int fails;
	int pending;
	int cycle_count = 0;

	// sender bookkeeping
	int         reqs_sent  = 0;
	int         burst_left = 0;
	logic [7:0] frame_data [$];

	// what the stimulus believes about the block, used to build frames that get deep
	// into page mode; the checker alone decides what is right
	logic [7:0] cur_major     = 8'h00;
	logic [7:0] cur_minor     = 8'h00;
	bit         page_mode     = 1'b0;
	logic [7:0] page_expected = 8'h00;
	logic [7:0] buf0_last     = 8'h00;

	bootloader_frame_receiver #(.PAGE_SIZE(PAGE_SIZE)) u_top (.*);

	bfr_checker #(.PAGE_SIZE(PAGE_SIZE)) u_chk (.*);

	always #5 clk = ~clk;

	// hard stop in case a handshake never completes
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// one request on the slave stream; the sender runs in bursts with random gaps
	task automatic push_req(input req_kind_t kind, input logic [7:0] b, input logic [15:0] pg,
			input logic [6:0] idx);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {1'b0, idx, pg, b};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		reqs_sent++;
	endtask

	// a serial byte, now and then preceded by a buffer read slipped in between
	task automatic send_byte(input logic [7:0] b, input logic [15:0] pg);
		logic [6:0] idx;
		if ($urandom_range(0, 9) == 0) begin
			// bias reads toward the low entries where page data usually sits
			idx = $urandom_range(0, 1) ? 7'($urandom_range(0, 23)) : 7'($urandom);
			push_req(KIND_READ, 8'($urandom), 16'($urandom), idx);
		end
		push_req(KIND_BYTE, b, pg, 7'($urandom));
	endtask

	task automatic set_payload(input int n);
		frame_data.delete();
		repeat (n) frame_data.push_back(8'($urandom));
	endtask

	// full frame around frame_data; expected page only matters on the last crc byte
	task automatic send_frame(input logic [7:0] mtype, input logic [15:0] pg_at_crc,
			input bit bad_crc);
		logic [7:0]  hdr [5];
		logic [15:0] fcs;
		logic [7:0]  len;
		len = 8'(frame_data.size());
		hdr[0] = 8'($urandom);  // flags
		hdr[1] = 8'($urandom);  // address
		hdr[2] = mtype;
		hdr[3] = 8'($urandom);  // per-section length, not interpreted
		hdr[4] = len;
		fcs = CRC_INIT;
		foreach (hdr[i]) fcs = crc_after(fcs, hdr[i]);
		foreach (frame_data[i]) fcs = crc_after(fcs, frame_data[i]);
		if (bad_crc) begin
			fcs ^= 16'(1 << $urandom_range(0, 15));
		end
		send_byte(START_BYTE, 16'($urandom));
		send_byte(START_BYTE, 16'($urandom));
		foreach (hdr[i]) send_byte(hdr[i], 16'($urandom));
		foreach (frame_data[i]) send_byte(frame_data[i], 16'($urandom));
		send_byte(fcs[15:8], 16'($urandom));
		send_byte(fcs[7:0], pg_at_crc);

		// follow the page mode and page number the block should now hold
		if (bad_crc) begin
			if (page_mode) page_expected = 8'h00;
		end else if (mtype == MSG_START) begin
			page_mode = !(len == 8'd2 && frame_data[0] == cur_major &&
				frame_data[1] == cur_minor);
		end else if (mtype == MSG_END) begin
			page_mode = 1'b0;
		end else if (page_mode && mtype == MSG_PAGE_NUM) begin
			page_expected = (len != 8'h00) ? frame_data[0] : buf0_last;
		end else if (page_mode && mtype == MSG_PAGE_DATA) begin
			if (int'(len) > PAGE_SIZE || {8'h00, page_expected} != pg_at_crc) begin
				page_expected = 8'h00;
			end
		end
		// entry zero is written even when the crc fails
		if (len != 8'h00) buf0_last = frame_data[0];
	endtask

	// stray bytes outside a frame: a bad first start byte, or a lone start byte
	// followed by a bad second one; the parser is back at the first start byte after
	task automatic send_noise();
		if ($urandom_range(0, 1)) send_byte(START_BYTE, 16'($urandom));
		send_byte(8'($urandom_range(0, 254)), 16'($urandom));
		if (page_mode) page_expected = 8'h00;
	endtask

	function automatic bit rare_bad();
		return $urandom_range(0, 9) == 0;
	endfunction

	function automatic int page_len();
		case ($urandom_range(0, 19))
			0: return PAGE_SIZE;
			1: return $urandom_range(PAGE_SIZE + 1, 255);
			default: return $urandom_range(0, 12);
		endcase
	endfunction

	// wait until every result is back; sampled at the falling edge so the checker's
	// update at the rising edge has already happened
	task automatic drain_results();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// setup cycle, then the access cycle; psel then goes idle so it never toggles twice
	task automatic reg_write(input cfg_reg_t r, input logic [7:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= reg_addr(r);
		pwdata  <= {24'h000000, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic directed_frames();
		// bad first start byte, then a good first and a bad second
		send_byte(8'h00, 16'h0000);
		send_byte(START_BYTE, 16'hFFFF);
		send_byte(8'hFE, 16'hFFFF);
		// nothing padded yet: reads give the pad byte at both ends
		push_req(KIND_READ, 8'hFF, 16'hFFFF, 7'd0);
		push_req(KIND_READ, 8'h00, 16'h0000, 7'd127);
		// page number outside page mode is ignored, but it fills entry zero
		set_payload(1);
		frame_data[0] = 8'h05;
		send_frame(MSG_PAGE_NUM, 16'h0005, 1'b0);
		// start with the installed version keeps page mode off
		set_payload(2);
		frame_data[0] = cur_major;
		frame_data[1] = cur_minor;
		send_frame(MSG_START, 16'h0000, 1'b0);
		// page data while page mode is off does nothing
		set_payload(3);
		send_frame(MSG_PAGE_DATA, 16'h0000, 1'b0);
		// a different minor version enters page mode
		set_payload(2);
		frame_data[0] = cur_major;
		frame_data[1] = cur_minor ^ 8'h01;
		send_frame(MSG_START, 16'hFFFF, 1'b0);
		// page number, then a matching four-byte page, read back across its end
		set_payload(1);
		frame_data[0] = 8'h07;
		send_frame(MSG_PAGE_NUM, 16'h0000, 1'b0);
		set_payload(4);
		send_frame(MSG_PAGE_DATA, 16'h0007, 1'b0);
		push_req(KIND_READ, 8'h00, 16'h0000, 7'd0);
		push_req(KIND_READ, 8'h00, 16'h0000, 7'd3);
		push_req(KIND_READ, 8'h00, 16'h0000, 7'd4);
		// right low byte, wrong high byte: the page compare is 16 bits wide
		set_payload(3);
		send_frame(MSG_PAGE_DATA, 16'hFF07, 1'b0);
		// crc mismatch while in page mode raises the signal line
		set_payload(2);
		send_frame(MSG_PAGE_NUM, 16'h0000, 1'b1);
		// page number with no data reuses whatever entry zero holds
		set_payload(0);
		send_frame(MSG_PAGE_NUM, 16'h0000, 1'b0);
		// empty page for that number
		set_payload(0);
		send_frame(MSG_PAGE_DATA, {8'h00, page_expected}, 1'b0);
		// one byte past the page: stored up to the page end, then refused
		set_payload(1);
		frame_data[0] = 8'hFF;
		send_frame(MSG_PAGE_NUM, 16'h0000, 1'b0);
		set_payload(PAGE_SIZE + 1);
		send_frame(MSG_PAGE_DATA, {8'h00, page_expected}, 1'b0);
		// page number lost by the error; set it again and send a full page
		set_payload(1);
		frame_data[0] = 8'hFF;
		send_frame(MSG_PAGE_NUM, 16'h0000, 1'b0);
		set_payload(PAGE_SIZE);
		send_frame(MSG_PAGE_DATA, 16'h00FF, 1'b0);
		push_req(KIND_READ, 8'h00, 16'h0000, 7'd126);
		push_req(KIND_READ, 8'h00, 16'h0000, 7'd127);
		// unknown type with no data
		set_payload(0);
		send_frame(8'h00, 16'h0000, 1'b0);
		// end of programming, then page data that is ignored again
		set_payload(0);
		send_frame(MSG_END, 16'h0000, 1'b0);
		set_payload(2);
		send_frame(MSG_PAGE_DATA, 16'h0000, 1'b0);
	endtask

	// start, a few page number / page data pairs, usually an end
	task automatic random_session();
		set_payload(($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) : 2);
		if (frame_data.size() >= 2) begin
			frame_data[0] = cur_major;
			frame_data[1] = cur_minor;
			// mostly one bit off, so that page mode is entered
			if ($urandom_range(0, 3) != 0) begin
				frame_data[$urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
			end
		end
		send_frame(MSG_START, 16'($urandom), rare_bad());
		repeat ($urandom_range(1, 4)) begin
			set_payload(($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3));
			send_frame(MSG_PAGE_NUM, 16'($urandom), rare_bad());
			repeat ($urandom_range(1, 2)) begin
				set_payload(page_len());
				send_frame(MSG_PAGE_DATA, ($urandom_range(0, 7) == 0) ?
					16'($urandom) : {8'h00, page_expected}, rare_bad());
			end
			if ($urandom_range(0, 5) == 0) send_noise();
		end
		if ($urandom_range(0, 4) != 0) begin
			set_payload($urandom_range(0, 2));
			send_frame(MSG_END, 16'($urandom), rare_bad());
		end
	endtask

	// entry zero is always written by the directed frames before any random frame
	task automatic random_traffic(input int count);
		int stop_at;
		stop_at = reqs_sent + count;
		while (reqs_sent < stop_at) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					set_payload($urandom_range(0, 6));
					send_frame(8'($urandom), 16'($urandom), rare_bad());
				end
				2: send_noise();
				default: random_session();
			endcase
		end
	endtask

	// result side: free-running, random and periodic stalls, plus a long hold-off now
	// and then that fills the block and pushes back on the sender
	initial begin : result_sink
		int span;
		int k;
		int since_hold;
		since_hold = 350;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (since_hold >= 500) begin
				span = $urandom_range(60, 120);
				m_tready <= 1'b0;
				repeat (span) @(posedge clk);
				since_hold = 0;
			end
			span = $urandom_range(8, 64);
			case ($urandom_range(0, 3))
				0: repeat (span) begin
					m_tready <= 1'b1;
					@(posedge clk);
				end
				1: repeat (span) begin
					m_tready <= 1'($urandom_range(0, 1));
					@(posedge clk);
				end
				2: begin
					k = $urandom_range(2, 5);
					for (int i = 0; i < span; i++) begin
						m_tready <= (i % k) == 0;
						@(posedge clk);
					end
				end
				default: repeat (span) begin
					m_tready <= $urandom_range(0, 7) != 0;
					@(posedge clk);
				end
			endcase
			since_hold += span;
		end
	end

	// main sequence: reset, then one phase per version setting; every phase begins
	// with the block idle, so the version registers are written only then
	initial begin : stimulus
		logic [7:0] maj;
		logic [7:0] min;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin maj = 8'h00; min = 8'hFF; end
				1: begin maj = 8'hFF; min = 8'h00; end
				2: begin maj = 8'($urandom); min = 8'($urandom); end
				3: begin maj = 8'hFF; min = 8'hFF; end
				default: begin maj = 8'h00; min = 8'h00; end
			endcase
			reg_write(REG_VER_MAJOR, maj);
			reg_write(REG_VER_MINOR, min);
			cur_major = maj;
			cur_minor = min;
			if (ph == 0) begin
				directed_frames();
			end else begin
				// what is left of the request budget, spread over the remaining phases
				random_traffic((REQ_TARGET - reqs_sent) / (5 - ph));
			end
			// sender pauses here until every result is back
			drain_results();
		end
		if (fails == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== bootloader_frame_receiver.f =====
design/bfr_pkg.sv
design/bfr_page_buf.sv
design/bfr_parser.sv
design/bootloader_frame_receiver.sv
tb/bfr_tb_pkg.sv
tb/bfr_checker.sv
tb/bootloader_frame_receiver_tb.sv
